>>> src/irfpe_pkg.sv
// Package with shared types, constants and tables of the IR frame pulse encoder.
`default_nettype none
package irfpe_pkg;

   localparam int FrameBytes = 21;
   localparam int FrameBits  = FrameBytes * 8;
   localparam int TimeWidth  = 14;

   typedef logic [TimeWidth-1:0] time_us_type;
   typedef logic [FrameBits-1:0] frame_type;
   typedef logic [7:0]           pos_type;

   typedef struct packed {
      time_us_type header_mark;
      time_us_type header_space;
      time_us_type bit_mark;
      time_us_type one_space;
      time_us_type zero_space;
      time_us_type part_gap_space;
      time_us_type trailer_space;
   } timing_type;

   // Request kinds.
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_NEXT  = 1'b1;

   // Configuration register indexes.
   localparam logic [2:0] CSR_HEADER_MARK    = 3'd0;
   localparam logic [2:0] CSR_HEADER_SPACE   = 3'd1;
   localparam logic [2:0] CSR_BIT_MARK       = 3'd2;
   localparam logic [2:0] CSR_ONE_SPACE      = 3'd3;
   localparam logic [2:0] CSR_ZERO_SPACE     = 3'd4;
   localparam logic [2:0] CSR_PART_GAP_SPACE = 3'd5;
   localparam logic [2:0] CSR_TRAILER_SPACE  = 3'd6;

   // Reset timing in microseconds.
   localparam time_us_type RST_HEADER_MARK    = 14'd9070;
   localparam time_us_type RST_HEADER_SPACE   = 14'd4520;
   localparam time_us_type RST_BIT_MARK       = 14'd580;
   localparam time_us_type RST_ONE_SPACE      = 14'd1680;
   localparam time_us_type RST_ZERO_SPACE     = 14'd580;
   localparam time_us_type RST_PART_GAP_SPACE = 14'd8050;
   localparam time_us_type RST_TRAILER_SPACE  = 14'd10120;

   // Commands.
   localparam logic [3:0] CMD_FULL_STATE = 4'd0;
   localparam logic [3:0] CMD_AUTO       = 4'd1;
   localparam logic [3:0] CMD_DRY        = 4'd2;
   localparam logic [3:0] CMD_FAN_ONLY   = 4'd3;
   localparam logic [3:0] CMD_POWER      = 4'd4;
   localparam logic [3:0] CMD_ECO_ON     = 4'd5;
   localparam logic [3:0] CMD_ECO_OFF    = 4'd6;
   localparam logic [3:0] CMD_SLEEP_ON   = 4'd7;
   localparam logic [3:0] CMD_SLEEP_OFF  = 4'd8;
   localparam logic [3:0] CMD_BOOST_ON   = 4'd9;
   localparam logic [3:0] CMD_BOOST_OFF  = 4'd10;
   localparam logic [3:0] CMD_DISPLAY    = 4'd11;
   localparam logic [3:0] CMD_VSWING     = 4'd12;
   localparam logic [3:0] CMD_HSWING     = 4'd13;

   // Tail selectors.
   localparam logic [3:0] TAIL_FULL_STATE = 4'd0;
   localparam logic [3:0] TAIL_DRY_FAN    = 4'd1;
   localparam logic [3:0] TAIL_AUTO       = 4'd2;
   localparam logic [3:0] TAIL_POWER      = 4'd3;
   localparam logic [3:0] TAIL_ECO_ON     = 4'd4;
   localparam logic [3:0] TAIL_ECO_OFF    = 4'd5;
   localparam logic [3:0] TAIL_SLEEP      = 4'd6;
   localparam logic [3:0] TAIL_BOOST      = 4'd7;
   localparam logic [3:0] TAIL_DISPLAY    = 4'd8;
   localparam logic [3:0] TAIL_VSWING     = 4'd9;
   localparam logic [3:0] TAIL_HSWING     = 4'd10;

   // Frame positions of the part boundaries.
   localparam pos_type POS_HEADER  = 8'd0;
   localparam pos_type POS_GAP0    = 8'd49;
   localparam pos_type POS_GAP1    = 8'd114;
   localparam pos_type POS_TRAILER = 8'd171;

   // The seven tail bytes, first byte in the low bits.
   function automatic logic [55:0] tail_bytes(input logic [3:0] sel);
      logic [55:0] t;
      case (sel)
         TAIL_FULL_STATE: t = {8'h19, 8'h00, 8'h08, 8'h00, 8'h00, 8'h11, 8'h00};
         TAIL_DRY_FAN:    t = {8'h0E, 8'h00, 8'h08, 8'h00, 8'h00, 8'h06, 8'h00};
         TAIL_AUTO:       t = {8'h1F, 8'h00, 8'h08, 8'h00, 8'h00, 8'h17, 8'h00};
         TAIL_POWER:      t = {8'h09, 8'h00, 8'h08, 8'h00, 8'h00, 8'h01, 8'h00};
         TAIL_ECO_ON:     t = {8'h24, 8'h00, 8'h08, 8'h00, 8'h00, 8'h0C, 8'h20};
         TAIL_ECO_OFF:    t = {8'h04, 8'h00, 8'h08, 8'h00, 8'h00, 8'h0C, 8'h00};
         TAIL_SLEEP:      t = {8'h0B, 8'h00, 8'h08, 8'h00, 8'h00, 8'h03, 8'h00};
         TAIL_BOOST:      t = {8'h0C, 8'h00, 8'h08, 8'h00, 8'h00, 8'h04, 8'h00};
         TAIL_DISPLAY:    t = {8'h08, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00};
         TAIL_VSWING:     t = {8'h0F, 8'h00, 8'h08, 8'h00, 8'h00, 8'h07, 8'h00};
         TAIL_HSWING:     t = {8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'h08, 8'h00};
         default:         t = {8'h19, 8'h00, 8'h08, 8'h00, 8'h00, 8'h11, 8'h00};
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

>>> src/irfpe_frame_build.sv
// Builds the 21-byte remote frame from a start request.
`default_nettype none
module irfpe_frame_build (
   input  wire logic [3:0]          command,
   input  wire logic [5:0]          target_temp,
   input  wire logic [1:0]          fan_speed,
   output irfpe_pkg::frame_type     frame
);

   logic [4:0]  temp_c;
   logic [3:0]  temp_ofs;
   logic [7:0]  tb;
   logic [7:0]  seq;
   logic [7:0]  b2, b3, b4, b5, b6, b7, b8, chk;
   logic [3:0]  tail_sel;

   always_comb begin
      if (target_temp < 6'd20) begin
         temp_c = 5'd20;
      end else if (target_temp > 6'd30) begin
         temp_c = 5'd30;
      end else begin
         temp_c = target_temp[4:0];
      end
      temp_ofs = 4'(temp_c - 5'd16);
      tb = {temp_ofs, 4'h2};
      if (temp_c <= 5'd23) begin
         seq = 8'h11;
      end else if (temp_c <= 5'd26) begin
         seq = 8'h12;
      end else begin
         seq = 8'h13;
      end
   end

   always_comb begin
      b4 = 8'h00;
      b5 = 8'h00;
      b8 = 8'h00;
      case (command)
         irfpe_pkg::CMD_AUTO: begin
            b2 = 8'h01; b3 = 8'h71; b6 = 8'h91; b7 = 8'h1E; b4 = 8'h80;
            tail_sel = irfpe_pkg::TAIL_AUTO;
         end
         irfpe_pkg::CMD_DRY: begin
            b2 = 8'h00; b3 = 8'h73; b6 = 8'h91; b7 = 8'h1E;
            tail_sel = irfpe_pkg::TAIL_DRY_FAN;
         end
         irfpe_pkg::CMD_FAN_ONLY: begin
            b2 = 8'h01; b3 = 8'h84; b6 = 8'h91; b7 = 8'h20;
            tail_sel = irfpe_pkg::TAIL_DRY_FAN;
         end
         irfpe_pkg::CMD_POWER: begin
            b2 = 8'h04; b3 = tb; b6 = 8'h8F; b7 = 8'h13;
            tail_sel = irfpe_pkg::TAIL_POWER;
         end
         irfpe_pkg::CMD_ECO_ON: begin
            b2 = 8'h03; b3 = tb; b6 = 8'h91; b7 = 8'h05;
            tail_sel = irfpe_pkg::TAIL_ECO_ON;
         end
         irfpe_pkg::CMD_ECO_OFF: begin
            b2 = 8'h00; b3 = tb; b6 = 8'h91; b7 = 8'h05;
            tail_sel = irfpe_pkg::TAIL_ECO_OFF;
         end
         irfpe_pkg::CMD_SLEEP_ON: begin
            b2 = 8'h08; b3 = tb; b6 = 8'h94; b7 = 8'h22;
            tail_sel = irfpe_pkg::TAIL_SLEEP;
         end
         irfpe_pkg::CMD_SLEEP_OFF: begin
            b2 = 8'h00; b3 = tb; b6 = 8'h94; b7 = 8'h22;
            tail_sel = irfpe_pkg::TAIL_SLEEP;
         end
         irfpe_pkg::CMD_BOOST_ON: begin
            b2 = 8'h01; b3 = 8'h02; b6 = 8'h97; b7 = 8'h39; b5 = 8'h90;
            tail_sel = irfpe_pkg::TAIL_BOOST;
         end
         irfpe_pkg::CMD_BOOST_OFF: begin
            b2 = 8'h00; b3 = tb; b6 = 8'h97; b7 = 8'h34;
            tail_sel = irfpe_pkg::TAIL_BOOST;
         end
         irfpe_pkg::CMD_DISPLAY: begin
            b2 = 8'h00; b3 = tb; b6 = 8'hB1; b7 = 8'h06;
            tail_sel = irfpe_pkg::TAIL_DISPLAY;
         end
         irfpe_pkg::CMD_VSWING: begin
            b2 = 8'h80; b3 = tb; b6 = 8'h94; b7 = 8'h23; b8 = 8'h40;
            tail_sel = irfpe_pkg::TAIL_VSWING;
         end
         irfpe_pkg::CMD_HSWING: begin
            b2 = 8'h00; b3 = tb; b6 = 8'h94; b7 = 8'h24; b8 = 8'h80;
            tail_sel = irfpe_pkg::TAIL_HSWING;
         end
         default: begin
            // Full state, also taken for the unused command codes.
            b2 = {6'd0, fan_speed}; b3 = tb; b6 = 8'h90; b7 = seq;
            tail_sel = irfpe_pkg::TAIL_FULL_STATE;
         end
      endcase
      chk = b2 ^ b3 ^ b4 ^ b5 ^ b6 ^ b7 ^ b8;
   end

   assign frame = {irfpe_pkg::tail_bytes(tail_sel), chk, 32'h0000_0000,
                   b8, b7, b6, b5, b4, b3, b2, 8'h06, 8'h83};

endmodule
`default_nettype wire

>>> src/irfpe_pulse_sel.sv
// Selects the mark and space of the pulse at the current frame position.
`default_nettype none
module irfpe_pulse_sel (
   input  wire irfpe_pkg::pos_type     pos,
   input  wire irfpe_pkg::frame_type   frame,
   input  wire irfpe_pkg::timing_type  timing,
   output irfpe_pkg::time_us_type      mark_us,
   output irfpe_pkg::time_us_type      space_us,
   output logic                        last_pulse
);

   logic [7:0]               bit_idx;
   irfpe_pkg::time_us_type   data_space;

   always_comb begin
      if (pos < irfpe_pkg::POS_GAP0) begin
         bit_idx = pos - 8'd1;
      end else if (pos < irfpe_pkg::POS_GAP1) begin
         bit_idx = pos - 8'd2;
      end else begin
         bit_idx = pos - 8'd3;
      end
      if (bit_idx < 8'(irfpe_pkg::FrameBits) && frame[bit_idx]) begin
         data_space = timing.one_space;
      end else begin
         data_space = timing.zero_space;
      end

      mark_us    = timing.bit_mark;
      space_us   = data_space;
      last_pulse = 1'b0;
      if (pos == irfpe_pkg::POS_HEADER) begin
         mark_us  = timing.header_mark;
         space_us = timing.header_space;
      end else if (pos == irfpe_pkg::POS_GAP0 || pos == irfpe_pkg::POS_GAP1) begin
         space_us = timing.part_gap_space;
      end else if (pos >= irfpe_pkg::POS_TRAILER) begin
         space_us   = timing.trailer_space;
         last_pulse = 1'b1;
      end
   end

endmodule
`default_nettype wire

>>> src/ir_ac_frame_pulse_encoder_unit.sv
// Top level of the IR air-conditioner frame pulse encoder.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid/req_stall    req_type, req_command, req_target_temp,
//                                              req_fan_speed
//   rsp      out        rsp_valid/rsp_stall    rsp_mark_us, rsp_space_us, rsp_last_pulse
//   csr      in         csr_write              csr_index, csr_data
//
// A pulse request yields its result in the cycle after acceptance; one request per cycle while req_stall is low.
// A start request builds the frame in the same cycle and gives no result.
// The result register holds a pending pulse; req_stall rises only while it is full
// and rsp_stall is high.
// Reset restores the default timing and returns the encoder to idle.
`default_nettype none
module ir_ac_frame_pulse_encoder_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic         req_type,
   input  wire logic [3:0]   req_command,
   input  wire logic [5:0]   req_target_temp,
   input  wire logic [1:0]   req_fan_speed,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [13:0]       rsp_mark_us,
   output logic [13:0]       rsp_space_us,
   output logic              rsp_last_pulse,
   input  wire logic         csr_write,
   input  wire logic [2:0]   csr_index,
   input  wire logic [13:0]  csr_data
);

   irfpe_pkg::timing_type    timing_ff, timing_in;
   irfpe_pkg::frame_type     frame_ff, frame_in, frame_built;
   irfpe_pkg::pos_type       pos_ff, pos_in;
   logic                     sending_ff, sending_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   irfpe_pkg::time_us_type   mark_ff, mark_in, space_ff, space_in;
   logic                     last_ff, last_in;
   irfpe_pkg::time_us_type   sel_mark, sel_space;
   logic                     sel_last;
   logic                     accept;
   logic                     emit;

   irfpe_frame_build u_build (
      .command     (req_command),
      .target_temp (req_target_temp),
      .fan_speed   (req_fan_speed),
      .frame       (frame_built)
   );

   irfpe_pulse_sel u_sel (
      .pos        (pos_ff),
      .frame      (frame_ff),
      .timing     (timing_ff),
      .mark_us    (sel_mark),
      .space_us   (sel_space),
      .last_pulse (sel_last)
   );

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign emit      = accept & (req_type == irfpe_pkg::REQ_NEXT) & sending_ff;

   always_comb begin
      timing_in = timing_ff;
      if (csr_write) begin
         case (csr_index)
            irfpe_pkg::CSR_HEADER_MARK:    timing_in.header_mark    = csr_data;
            irfpe_pkg::CSR_HEADER_SPACE:   timing_in.header_space   = csr_data;
            irfpe_pkg::CSR_BIT_MARK:       timing_in.bit_mark       = csr_data;
            irfpe_pkg::CSR_ONE_SPACE:      timing_in.one_space      = csr_data;
            irfpe_pkg::CSR_ZERO_SPACE:     timing_in.zero_space     = csr_data;
            irfpe_pkg::CSR_PART_GAP_SPACE: timing_in.part_gap_space = csr_data;
            irfpe_pkg::CSR_TRAILER_SPACE:  timing_in.trailer_space  = csr_data;
            default:                       timing_in                = timing_ff;
         endcase
      end
   end

   always_comb begin
      frame_in   = frame_ff;
      pos_in     = pos_ff;
      sending_in = sending_ff;
      if (accept && req_type == irfpe_pkg::REQ_START) begin
         frame_in   = frame_built;
         pos_in     = irfpe_pkg::POS_HEADER;
         sending_in = 1'b1;
      end else if (emit) begin
         if (sel_last) begin
            pos_in     = irfpe_pkg::POS_HEADER;
            sending_in = 1'b0;
         end else begin
            pos_in = pos_ff + 8'd1;
         end
      end
   end

   always_comb begin
      mark_in  = mark_ff;
      space_in = space_ff;
      last_in  = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         mark_in      = sel_mark;
         space_in     = sel_space;
         last_in      = sel_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.header_mark    <= irfpe_pkg::RST_HEADER_MARK;
         timing_ff.header_space   <= irfpe_pkg::RST_HEADER_SPACE;
         timing_ff.bit_mark       <= irfpe_pkg::RST_BIT_MARK;
         timing_ff.one_space      <= irfpe_pkg::RST_ONE_SPACE;
         timing_ff.zero_space     <= irfpe_pkg::RST_ZERO_SPACE;
         timing_ff.part_gap_space <= irfpe_pkg::RST_PART_GAP_SPACE;
         timing_ff.trailer_space  <= irfpe_pkg::RST_TRAILER_SPACE;
         pos_ff                   <= irfpe_pkg::POS_HEADER;
         sending_ff               <= 1'b0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         timing_ff    <= timing_in;
         pos_ff       <= pos_in;
         sending_ff   <= sending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      mark_ff  <= mark_in;
      space_ff <= space_in;
      last_ff  <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mark_us    = mark_ff;
   assign rsp_space_us   = space_ff;
   assign rsp_last_pulse = last_ff;

endmodule
`default_nettype wire

>>> bench/tb_ir_ac_frame_pulse_encoder_unit.sv
// Self-checking testbench for the IR air-conditioner frame pulse encoder.
`timescale 1ns / 1ps
module tb_ir_ac_frame_pulse_encoder_unit;

   localparam logic [3:0] CMD_SPARE_LO = 4'd14;
   localparam logic [3:0] CMD_SPARE_HI = 4'd15;
   localparam int PART1_BYTE = 6;
   localparam int PART2_BYTE = 14;
   localparam int PULSES_PER_FRAME = int'(irfpe_pkg::POS_TRAILER) + 1;

   typedef struct packed {
      logic       kind;
      logic [3:0] command;
      logic [5:0] temp;
      logic [1:0] fan;
   } encoder_request_type;

   typedef struct packed {
      irfpe_pkg::time_us_type mark;
      irfpe_pkg::time_us_type space;
      logic                   last;
   } ir_pulse_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = irfpe_pkg::REQ_START;
   logic [3:0]  req_command = '0;
   logic [5:0]  req_target_temp = '0;
   logic [1:0]  req_fan_speed = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [13:0] rsp_mark_us;
   logic [13:0] rsp_space_us;
   logic        rsp_last_pulse;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [13:0] csr_data = '0;

   encoder_request_type pending_requests[$];
   ir_pulse_type        expected_pulses[$];
   logic [3:0]          commands_to_cover[$];
   int                  mismatches = 0;
   bit                  no_idle = 1'b0;
   bit                  hold_armed = 1'b0;
   bit                  hold_done = 1'b0;
   int                  hold_left = 0;

   irfpe_pkg::timing_type  timing;
   logic [7:0]             frame_bytes [irfpe_pkg::FrameBytes];
   irfpe_pkg::pos_type     pulse_pos;
   bit                     sending;

   ir_ac_frame_pulse_encoder_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_command     (req_command),
      .req_target_temp (req_target_temp),
      .req_fan_speed   (req_fan_speed),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_mark_us     (rsp_mark_us),
      .rsp_space_us    (rsp_space_us),
      .rsp_last_pulse  (rsp_last_pulse),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] tail_byte(input logic [3:0] sel, input int i);
      logic [0:6][7:0] row;
      case (sel)
         irfpe_pkg::TAIL_DRY_FAN:
            row = {8'h00, 8'h06, 8'h00, 8'h00, 8'h08, 8'h00, 8'h0E};
         irfpe_pkg::TAIL_AUTO:
            row = {8'h00, 8'h17, 8'h00, 8'h00, 8'h08, 8'h00, 8'h1F};
         irfpe_pkg::TAIL_POWER:
            row = {8'h00, 8'h01, 8'h00, 8'h00, 8'h08, 8'h00, 8'h09};
         irfpe_pkg::TAIL_ECO_ON:
            row = {8'h20, 8'h0C, 8'h00, 8'h00, 8'h08, 8'h00, 8'h24};
         irfpe_pkg::TAIL_ECO_OFF:
            row = {8'h00, 8'h0C, 8'h00, 8'h00, 8'h08, 8'h00, 8'h04};
         irfpe_pkg::TAIL_SLEEP:
            row = {8'h00, 8'h03, 8'h00, 8'h00, 8'h08, 8'h00, 8'h0B};
         irfpe_pkg::TAIL_BOOST:
            row = {8'h00, 8'h04, 8'h00, 8'h00, 8'h08, 8'h00, 8'h0C};
         irfpe_pkg::TAIL_DISPLAY:
            row = {8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h08};
         irfpe_pkg::TAIL_VSWING:
            row = {8'h00, 8'h07, 8'h00, 8'h00, 8'h08, 8'h00, 8'h0F};
         irfpe_pkg::TAIL_HSWING:
            row = {8'h00, 8'h08, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00};
         default:
            row = {8'h00, 8'h11, 8'h00, 8'h00, 8'h08, 8'h00, 8'h19};
      endcase
      return row[i];
   endfunction

   function automatic void load_frame(input logic [3:0] cmd, input logic [5:0] temp,
                                      input logic [1:0] fan);
      logic [7:0] t;
      logic [7:0] tb;
      logic [7:0] band;
      logic [7:0] b2, b3, b4, b5, b6, b7, b8;
      logic [3:0] tail;
      t = (temp < 6'd20) ? 8'd20 : ((temp > 6'd30) ? 8'd30 : {2'b00, temp});
      tb = ((t - 8'd16) << 4) | 8'h02;
      band = (t <= 8'd23) ? 8'h11 : ((t <= 8'd26) ? 8'h12 : 8'h13);
      b3 = tb;
      b4 = 8'h00;
      b5 = 8'h00;
      b8 = 8'h00;
      case (cmd)
         irfpe_pkg::CMD_AUTO: begin
            b2 = 8'h01; b3 = 8'h71; b4 = 8'h80; b6 = 8'h91; b7 = 8'h1E;
            tail = irfpe_pkg::TAIL_AUTO;
         end
         irfpe_pkg::CMD_DRY: begin
            b2 = 8'h00; b3 = 8'h73; b6 = 8'h91; b7 = 8'h1E; tail = irfpe_pkg::TAIL_DRY_FAN;
         end
         irfpe_pkg::CMD_FAN_ONLY: begin
            b2 = 8'h01; b3 = 8'h84; b6 = 8'h91; b7 = 8'h20; tail = irfpe_pkg::TAIL_DRY_FAN;
         end
         irfpe_pkg::CMD_POWER: begin
            b2 = 8'h04; b6 = 8'h8F; b7 = 8'h13; tail = irfpe_pkg::TAIL_POWER;
         end
         irfpe_pkg::CMD_ECO_ON: begin
            b2 = 8'h03; b6 = 8'h91; b7 = 8'h05; tail = irfpe_pkg::TAIL_ECO_ON;
         end
         irfpe_pkg::CMD_ECO_OFF: begin
            b2 = 8'h00; b6 = 8'h91; b7 = 8'h05; tail = irfpe_pkg::TAIL_ECO_OFF;
         end
         irfpe_pkg::CMD_SLEEP_ON: begin
            b2 = 8'h08; b6 = 8'h94; b7 = 8'h22; tail = irfpe_pkg::TAIL_SLEEP;
         end
         irfpe_pkg::CMD_SLEEP_OFF: begin
            b2 = 8'h00; b6 = 8'h94; b7 = 8'h22; tail = irfpe_pkg::TAIL_SLEEP;
         end
         irfpe_pkg::CMD_BOOST_ON: begin
            b2 = 8'h01; b3 = 8'h02; b5 = 8'h90; b6 = 8'h97; b7 = 8'h39;
            tail = irfpe_pkg::TAIL_BOOST;
         end
         irfpe_pkg::CMD_BOOST_OFF: begin
            b2 = 8'h00; b6 = 8'h97; b7 = 8'h34; tail = irfpe_pkg::TAIL_BOOST;
         end
         irfpe_pkg::CMD_DISPLAY: begin
            b2 = 8'h00; b6 = 8'hB1; b7 = 8'h06; tail = irfpe_pkg::TAIL_DISPLAY;
         end
         irfpe_pkg::CMD_VSWING: begin
            b2 = 8'h80; b6 = 8'h94; b7 = 8'h23; b8 = 8'h40; tail = irfpe_pkg::TAIL_VSWING;
         end
         irfpe_pkg::CMD_HSWING: begin
            b2 = 8'h00; b6 = 8'h94; b7 = 8'h24; b8 = 8'h80; tail = irfpe_pkg::TAIL_HSWING;
         end
         default: begin
            b2 = {6'b0, fan}; b6 = 8'h90; b7 = band; tail = irfpe_pkg::TAIL_FULL_STATE;
         end
      endcase
      frame_bytes[0] = 8'h83;
      frame_bytes[1] = 8'h06;
      frame_bytes[2] = b2;
      frame_bytes[3] = b3;
      frame_bytes[4] = b4;
      frame_bytes[5] = b5;
      frame_bytes[6] = b6;
      frame_bytes[7] = b7;
      frame_bytes[8] = b8;
      for (int i = 9; i < 13; i++) frame_bytes[i] = 8'h00;
      frame_bytes[13] = b2 ^ b3 ^ b4 ^ b5 ^ b6 ^ b7 ^ b8;
      for (int i = 0; i < 7; i++) frame_bytes[PART2_BYTE + i] = tail_byte(tail, i);
   endfunction

   function automatic irfpe_pkg::time_us_type bit_space(input int k, input int base);
      return frame_bytes[base + k / 8][k % 8] ? timing.one_space : timing.zero_space;
   endfunction

   function automatic void predict_request(input encoder_request_type r);
      ir_pulse_type pl;
      int p;
      if (r.kind == irfpe_pkg::REQ_START) begin
         load_frame(r.command, r.temp, r.fan);
         pulse_pos = irfpe_pkg::POS_HEADER;
         sending = 1'b1;
      end else if (sending) begin
         p = int'(pulse_pos);
         pl.mark = timing.bit_mark;
         pl.last = 1'b0;
         if (p == int'(irfpe_pkg::POS_HEADER)) begin
            pl.mark = timing.header_mark;
            pl.space = timing.header_space;
         end else if (p < int'(irfpe_pkg::POS_GAP0)) begin
            pl.space = bit_space(p - 1, 0);
         end else if (p == int'(irfpe_pkg::POS_GAP0)) begin
            pl.space = timing.part_gap_space;
         end else if (p < int'(irfpe_pkg::POS_GAP1)) begin
            pl.space = bit_space(p - int'(irfpe_pkg::POS_GAP0) - 1, PART1_BYTE);
         end else if (p == int'(irfpe_pkg::POS_GAP1)) begin
            pl.space = timing.part_gap_space;
         end else if (p < int'(irfpe_pkg::POS_TRAILER)) begin
            pl.space = bit_space(p - int'(irfpe_pkg::POS_GAP1) - 1, PART2_BYTE);
         end else begin
            pl.space = timing.trailer_space;
            pl.last = 1'b1;
         end
         if (pl.last) begin
            sending = 1'b0;
            pulse_pos = irfpe_pkg::POS_HEADER;
         end else begin
            pulse_pos = pulse_pos + 8'd1;
         end
         expected_pulses.push_back(pl);
      end
   endfunction

   function automatic void queue_start(input logic [3:0] c, input logic [5:0] t,
                                       input logic [1:0] f);
      encoder_request_type r;
      r.kind = irfpe_pkg::REQ_START;
      r.command = c;
      r.temp = t;
      r.fan = f;
      pending_requests.push_back(r);
   endfunction

   function automatic void queue_pulses(input int n);
      encoder_request_type r;
      for (int i = 0; i < n; i++) begin
         r.kind = irfpe_pkg::REQ_NEXT;
         r.command = 4'($urandom_range(0, 15));
         r.temp = 6'($urandom_range(0, 63));
         r.fan = 2'($urandom_range(0, 3));
         pending_requests.push_back(r);
      end
   endfunction

   function automatic logic [5:0] pick_temp();
      case ($urandom_range(0, 4))
         0: return 6'd0;
         1: return 6'd63;
         2: return 6'($urandom_range(18, 32));
         default: return 6'($urandom_range(0, 63));
      endcase
   endfunction

   function automatic void queue_frame();
      logic [3:0] c;
      c = (commands_to_cover.size() != 0) ? commands_to_cover.pop_front()
                                          : 4'($urandom_range(0, 15));
      queue_start(c, pick_temp(), 2'($urandom_range(0, 3)));
      queue_pulses(PULSES_PER_FRAME);
   endfunction

   function automatic void queue_partial(input int lo, input int hi);
      queue_start(4'($urandom_range(0, 15)), pick_temp(), 2'($urandom_range(0, 3)));
      queue_pulses(int'($urandom_range(lo, hi)));
   endfunction

   task automatic write_reg(input logic [2:0] idx, input irfpe_pkg::time_us_type v);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      case (idx)
         irfpe_pkg::CSR_HEADER_MARK:    timing.header_mark = v;
         irfpe_pkg::CSR_HEADER_SPACE:   timing.header_space = v;
         irfpe_pkg::CSR_BIT_MARK:       timing.bit_mark = v;
         irfpe_pkg::CSR_ONE_SPACE:      timing.one_space = v;
         irfpe_pkg::CSR_ZERO_SPACE:     timing.zero_space = v;
         irfpe_pkg::CSR_PART_GAP_SPACE: timing.part_gap_space = v;
         default:                       timing.trailer_space = v;
      endcase
   endtask

   task automatic program_timing(input irfpe_pkg::timing_type t);
      write_reg(irfpe_pkg::CSR_HEADER_MARK, t.header_mark);
      write_reg(irfpe_pkg::CSR_HEADER_SPACE, t.header_space);
      write_reg(irfpe_pkg::CSR_BIT_MARK, t.bit_mark);
      write_reg(irfpe_pkg::CSR_ONE_SPACE, t.one_space);
      write_reg(irfpe_pkg::CSR_ZERO_SPACE, t.zero_space);
      write_reg(irfpe_pkg::CSR_PART_GAP_SPACE, t.part_gap_space);
      write_reg(irfpe_pkg::CSR_TRAILER_SPACE, t.trailer_space);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || expected_pulses.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // The request is predicted at the edge where it is accepted.
   always @(posedge clock) begin
      encoder_request_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predict_request({req_type, req_command, req_target_temp, req_fan_speed});
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 && (no_idle || $urandom_range(0, 99) >= 29)) begin
               r = pending_requests.pop_front();
               req_type <= r.kind;
               req_command <= r.command;
               req_target_temp <= r.temp;
               req_fan_speed <= r.fan;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      ir_pulse_type got;
      ir_pulse_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_mark_us, rsp_space_us, rsp_last_pulse};
            if (expected_pulses.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected pulse: mark %0d space %0d last %0b",
                           got.mark, got.space, got.last);
               mismatches++;
            end else begin
               want = expected_pulses.pop_front();
               if (got.mark !== want.mark || got.space !== want.space ||
                   got.last !== want.last) begin
                  if (mismatches < 10)
                     $display("pulse mismatch: expected mark %0d space %0d last %0b,",
                              want.mark, want.space, want.last,
                              " got mark %0d space %0d last %0b",
                              got.mark, got.space, got.last);
                  mismatches++;
               end
            end
         end
         if (hold_armed && !hold_done && rsp_valid) begin
            hold_left = 150;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(0, 99) < 29);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      irfpe_pkg::timing_type t;
      int j;
      logic [3:0] swap;
      timing.header_mark = irfpe_pkg::RST_HEADER_MARK;
      timing.header_space = irfpe_pkg::RST_HEADER_SPACE;
      timing.bit_mark = irfpe_pkg::RST_BIT_MARK;
      timing.one_space = irfpe_pkg::RST_ONE_SPACE;
      timing.zero_space = irfpe_pkg::RST_ZERO_SPACE;
      timing.part_gap_space = irfpe_pkg::RST_PART_GAP_SPACE;
      timing.trailer_space = irfpe_pkg::RST_TRAILER_SPACE;
      pulse_pos = irfpe_pkg::POS_HEADER;
      sending = 1'b0;
      for (int i = 0; i < 16; i++) commands_to_cover.push_back(4'(i));
      for (int i = 15; i > 0; i--) begin
         j = int'($urandom_range(0, i));
         swap = commands_to_cover[i];
         commands_to_cover[i] = commands_to_cover[j];
         commands_to_cover[j] = swap;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         if (phase != 0) begin
            wait_drained();
            case (phase)
               1: t = '0;
               2: t = '1;
               default: begin
                  t.header_mark = 14'($urandom_range(0, 16383));
                  t.header_space = 14'($urandom_range(0, 16383));
                  t.bit_mark = 14'($urandom_range(0, 16383));
                  t.one_space = 14'($urandom_range(0, 16383));
                  t.zero_space = 14'($urandom_range(0, 16383));
                  t.part_gap_space = 14'($urandom_range(0, 16383));
                  t.trailer_space = 14'($urandom_range(0, 16383));
               end
            endcase
            program_timing(t);
         end
         @(negedge clock);
         no_idle = (phase == 2);
         hold_armed = (phase == 3);
         if (phase == 0) begin
            // A pulse request while idle, then restarts in the middle of a frame with
            // saturated temperatures and the unused command codes.
            queue_pulses(1);
            queue_start(irfpe_pkg::CMD_FULL_STATE, 6'd0, 2'd3);
            queue_pulses(3);
            queue_start(CMD_SPARE_HI, 6'd63, 2'd0);
            queue_pulses(2);
            queue_start(CMD_SPARE_LO, 6'd19, 2'd1);
            queue_pulses(1);
            queue_start(irfpe_pkg::CMD_HSWING, 6'd30, 2'd2);
            queue_pulses(2);
            queue_start(irfpe_pkg::CMD_AUTO, 6'd20, 2'd3);
            queue_pulses(3);
         end
         case (phase)
            0, 2: queue_frame();
            1: queue_partial(5, 20);
            default: queue_partial(30, 60);
         endcase
      end
      wait_drained();
      if (mismatches == 0 && expected_pulses.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> files.f
src/irfpe_pkg.sv
src/irfpe_frame_build.sv
src/irfpe_pulse_sel.sv
src/ir_ac_frame_pulse_encoder_unit.sv
bench/tb_ir_ac_frame_pulse_encoder_unit.sv
